// ===== rtl/cfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfm_pkg
// Types and constants shared by the capture frequency meter modules.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int unsigned DATA_W     = 16;
   localparam int unsigned STEP_CNT_W = 4;

   localparam logic [DATA_W-1:0]     TICK_RATE_RESET = 16'd62500;
   localparam logic [STEP_CNT_W-1:0] LAST_STEP       = 4'd15;

   localparam logic EVENT_CAPTURE  = 1'b0;
   localparam logic EVENT_OVERFLOW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUBLISH
   } cfm_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic div_last;
      logic publish;
   } cfm_cmd_type;

   typedef struct packed {
      logic overflow;
      logic period_zero;
   } cfm_status_type;

endpackage : cfm_pkg
`default_nettype wire

// ===== rtl/cfm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfm_ctrl
// Sequencer: takes a request, steps the divider unless it is an overflow or zero
// period, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cfm_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  cfm_pkg::cfm_status_type status,
   output cfm_pkg::cfm_cmd_type    cmd
);
   import cfm_pkg::*;

   cfm_state_type         state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               if (status.overflow || status.period_zero) begin
                  state_in = ST_PUBLISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               cmd.div_last = 1'b1;
               state_in     = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // The result waits here only while the previous one is still unread.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule : cfm_ctrl
`default_nettype wire

// ===== rtl/cfm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfm_datapath
// Capture state, period subtractor, restoring divider and output register.
// ----------------------------------------------------------------------------
module cfm_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire  [cfm_pkg::DATA_W-1:0]     csr_wdata,
   input  wire                            req_tuser,
   input  wire  [cfm_pkg::DATA_W-1:0]     req_tdata,
   input  cfm_pkg::cfm_cmd_type           cmd,
   output cfm_pkg::cfm_status_type        status,
   output logic [2*cfm_pkg::DATA_W-1:0]   rsp_tdata
);
   import cfm_pkg::*;

   logic [DATA_W-1:0]   tick_rate_ff;
   logic [DATA_W-1:0]   prev_ff, prev_in;
   logic [DATA_W-1:0]   period_ff, period_in;
   logic [DATA_W-1:0]   freq_ff, freq_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [2*DATA_W-1:0] out_ff;
   logic [DATA_W-1:0]   period_calc;
   logic [DATA_W:0]     shifted;
   logic [DATA_W:0]     diff;
   logic                fits;

   assign period_calc = req_tdata - prev_ff;

   assign status.overflow    = (req_tuser == EVENT_OVERFLOW);
   assign status.period_zero = (period_calc == '0);

   // One quotient bit a cycle; the partial remainder stays below the divisor.
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, period_ff};
   assign fits    = (shifted >= {1'b0, period_ff});

   always_comb begin
      prev_in   = prev_ff;
      period_in = period_ff;
      freq_in   = freq_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (cmd.accept) begin
         if (req_tuser == EVENT_CAPTURE) begin
            prev_in   = req_tdata;
            period_in = period_calc;
            rem_in    = '0;
            quo_in    = tick_rate_ff;
         end else begin
            prev_in = '0;
         end
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
      end
      if (cmd.div_last) begin
         freq_in = quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
         prev_ff      <= '0;
         period_ff    <= '0;
         freq_ff      <= '0;
      end else begin
         if (csr_we) begin
            tick_rate_ff <= csr_wdata;
         end
         prev_ff   <= prev_in;
         period_ff <= period_in;
         freq_ff   <= freq_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.publish) begin
         out_ff <= {period_ff, freq_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule : cfm_datapath
`default_nettype wire

// ===== rtl/capture_frequency_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capture_frequency_meter_top
// Input capture frequency meter: period between captures and tick_rate /
// period, reported once per timer event.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_*     in         tuser event kind, tdata capture time
//  rsp_*     out        tdata frequency, period
//  csr_*     in         tick_rate write
//
//  A capture with a nonzero period is answered once the 16-step restoring
//  divider, one quotient bit a cycle, has run; an overflow or a zero-period
//  capture skips the divider. The next request is taken once the result is
//  published; an unread result holds the next one in the sequencer until
//  it is taken. Reset is synchronous; tick_rate returns to 62500, the
//  divider and output registers are not reset; all else returns to zero.
// ----------------------------------------------------------------------------
module capture_frequency_meter_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [15:0] csr_wdata,   // tick_rate
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] capture_time
   input  wire         req_tuser,   // [0] event_kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] frequency, [31:16] period
);
   import cfm_pkg::*;

   cfm_cmd_type    cmd;
   cfm_status_type status;

   cfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule : capture_frequency_meter_top
`default_nettype wire
